// File: sv/spar_pkg.sv
// Shared constants, tables and types for the shoulder-aligned point rotation core.
`default_nettype none

package spar_pkg;

   localparam int DEFAULT_COORD_WIDTH   = 16;
   localparam int DEFAULT_CORDIC_STAGES = 16;
   localparam int MAX_STAGES            = 24;
   localparam int FRAC_BITS             = 8;
   localparam int GUARD_BITS            = 11;
   localparam int ACC_WIDTH             = 27;
   localparam int OUT_WIDTH             = 17;
   localparam int KINV_WIDTH            = 21;
   localparam int GAIN_SHIFT            = 20 + FRAC_BITS;
   localparam int THRESHOLD_WIDTH       = 7;
   localparam int ADDR_WIDTH            = 2;
   localparam int CSR_DATA_WIDTH        = 32;

   localparam logic [ADDR_WIDTH-1:0]      REG_THRESHOLD_ADDR = '0;
   localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET    = 7'd30;

   localparam logic signed [KINV_WIDTH-1:0] KINV_Q20       = 21'sd636751;
   localparam logic signed [ACC_WIDTH-1:0]  HALF_TURN_ACC  = 27'sd11796480;
   localparam logic signed [ACC_WIDTH-1:0]  HALF_TURN_OUT  = 27'sd46080;
   localparam logic signed [ACC_WIDTH-1:0]  FULL_TURN_OUT  = 27'sd92160;
   localparam logic signed [ACC_WIDTH-1:0]  ANGLE_ROUND    = 27'sd128;
   localparam logic signed [OUT_WIDTH-1:0]  OUT_MIN        = -17'sd65536;
   localparam logic signed [OUT_WIDTH-1:0]  OUT_MAX        = 17'sd65535;

   localparam logic [1:0] FACING_FORWARD = 2'd0;
   localparam logic [1:0] FACING_LEFT    = 2'd1;
   localparam logic [1:0] FACING_RIGHT   = 2'd2;

   // atan(2^-i) in 1/65536 degree.
   localparam logic signed [ACC_WIDTH-1:0] ATAN_TABLE [MAX_STAGES] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379, 27'sd117304,
      27'sd58666,   27'sd29335,   27'sd14668,  27'sd7334,   27'sd3667,   27'sd1833,
      27'sd917,     27'sd458,     27'sd229,    27'sd115,    27'sd57,     27'sd29,
      27'sd14,      27'sd7,       27'sd4,      27'sd2,      27'sd1,      27'sd0
   };

   typedef struct packed {
      logic valid;
      logic degenerate;
      logic dz_zero;
      logic dx_neg;
   } spar_flags_type;

endpackage

`default_nettype wire

// File: sv/spar_prep.sv
// Front stage: shoulder vector, half-turn pre-rotation and fixed-point scaling.
`default_nettype none

module spar_prep import spar_pkg::*; #(
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH,
   parameter int DATA_WIDTH  = DEFAULT_COORD_WIDTH + GUARD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic signed [COORD_WIDTH-1:0] left_shoulder_x,
   input  wire logic signed [COORD_WIDTH-1:0] left_shoulder_z,
   input  wire logic signed [COORD_WIDTH-1:0] right_shoulder_x,
   input  wire logic signed [COORD_WIDTH-1:0] right_shoulder_z,
   input  wire logic signed [COORD_WIDTH-1:0] start_x,
   input  wire logic signed [COORD_WIDTH-1:0] start_z,
   input  wire logic signed [COORD_WIDTH-1:0] end_x,
   input  wire logic signed [COORD_WIDTH-1:0] end_z,
   output logic signed [DATA_WIDTH-1:0]       vx,
   output logic signed [DATA_WIDTH-1:0]       vy,
   output logic signed [DATA_WIDTH-1:0]       sx,
   output logic signed [DATA_WIDTH-1:0]       sz,
   output logic signed [DATA_WIDTH-1:0]       ex,
   output logic signed [DATA_WIDTH-1:0]       ez,
   output logic signed [ACC_WIDTH-1:0]        acc,
   output spar_flags_type                     flags
);

   logic signed [COORD_WIDTH:0]   dx, dz;
   logic signed [DATA_WIDTH-1:0]  vx_raw, vy_raw, sx_raw, sz_raw, ex_raw, ez_raw;
   logic signed [DATA_WIDTH-1:0]  vx_in, vy_in, sx_in, sz_in, ex_in, ez_in;
   logic signed [DATA_WIDTH-1:0]  vx_ff, vy_ff, sx_ff, sz_ff, ex_ff, ez_ff;
   logic signed [ACC_WIDTH-1:0]   acc_in, acc_ff;
   spar_flags_type                flags_in, flags_ff;
   logic                          neg;

   always_comb begin
      dx = (COORD_WIDTH+1)'(right_shoulder_x) - (COORD_WIDTH+1)'(left_shoulder_x);
      dz = (COORD_WIDTH+1)'(right_shoulder_z) - (COORD_WIDTH+1)'(left_shoulder_z);
      neg = dx[COORD_WIDTH];

      vx_raw = DATA_WIDTH'(dx) <<< FRAC_BITS;
      vy_raw = DATA_WIDTH'(dz) <<< FRAC_BITS;
      sx_raw = DATA_WIDTH'(start_x) <<< FRAC_BITS;
      sz_raw = DATA_WIDTH'(start_z) <<< FRAC_BITS;
      ex_raw = DATA_WIDTH'(end_x) <<< FRAC_BITS;
      ez_raw = DATA_WIDTH'(end_z) <<< FRAC_BITS;

      // A vector in the left half-plane is turned by half a turn first, so the
      // micro-rotations only ever need to cover the right half-plane.
      vx_in = neg ? -vx_raw : vx_raw;
      vy_in = neg ? -vy_raw : vy_raw;
      sx_in = neg ? -sx_raw : sx_raw;
      sz_in = neg ? -sz_raw : sz_raw;
      ex_in = neg ? -ex_raw : ex_raw;
      ez_in = neg ? -ez_raw : ez_raw;

      if (!neg) begin
         acc_in = '0;
      end else if (dz[COORD_WIDTH]) begin
         acc_in = -HALF_TURN_ACC;
      end else begin
         acc_in = HALF_TURN_ACC;
      end

      flags_in.valid      = accept;
      flags_in.degenerate = (dx == '0) && (dz == '0);
      flags_in.dz_zero    = (dz == '0);
      flags_in.dx_neg     = neg;
   end

   always_ff @(posedge clock) begin
      vx_ff  <= vx_in;
      vy_ff  <= vy_in;
      sx_ff  <= sx_in;
      sz_ff  <= sz_in;
      ex_ff  <= ex_in;
      ez_ff  <= ez_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   assign vx    = vx_ff;
   assign vy    = vy_ff;
   assign sx    = sx_ff;
   assign sz    = sz_ff;
   assign ex    = ex_ff;
   assign ez    = ez_ff;
   assign acc   = acc_ff;
   assign flags = flags_ff;

endmodule

`default_nettype wire

// File: sv/spar_cell.sv
// One CORDIC micro-rotation cell: vectoring on the shoulder vector, same turn on both points.
`default_nettype none

module spar_cell import spar_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_COORD_WIDTH + GUARD_BITS,
   parameter int STAGE      = 0
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic signed [DATA_WIDTH-1:0] vx_i,
   input  wire logic signed [DATA_WIDTH-1:0] vy_i,
   input  wire logic signed [DATA_WIDTH-1:0] sx_i,
   input  wire logic signed [DATA_WIDTH-1:0] sz_i,
   input  wire logic signed [DATA_WIDTH-1:0] ex_i,
   input  wire logic signed [DATA_WIDTH-1:0] ez_i,
   input  wire logic signed [ACC_WIDTH-1:0]  acc_i,
   input  wire spar_flags_type               flags_i,
   output logic signed [DATA_WIDTH-1:0]      vx_o,
   output logic signed [DATA_WIDTH-1:0]      vy_o,
   output logic signed [DATA_WIDTH-1:0]      sx_o,
   output logic signed [DATA_WIDTH-1:0]      sz_o,
   output logic signed [DATA_WIDTH-1:0]      ex_o,
   output logic signed [DATA_WIDTH-1:0]      ez_o,
   output logic signed [ACC_WIDTH-1:0]       acc_o,
   output spar_flags_type                    flags_o
);

   logic                          cw;
   logic signed [DATA_WIDTH-1:0]  vx_in, vy_in, sx_in, sz_in, ex_in, ez_in;
   logic signed [DATA_WIDTH-1:0]  vx_ff, vy_ff, sx_ff, sz_ff, ex_ff, ez_ff;
   logic signed [ACC_WIDTH-1:0]   acc_in, acc_ff;
   spar_flags_type                flags_ff;

   always_comb begin
      // A non-negative y component means the vector still lies above the axis.
      cw = !vy_i[DATA_WIDTH-1];
      if (cw) begin
         vx_in  = vx_i + (vy_i >>> STAGE);
         vy_in  = vy_i - (vx_i >>> STAGE);
         sx_in  = sx_i + (sz_i >>> STAGE);
         sz_in  = sz_i - (sx_i >>> STAGE);
         ex_in  = ex_i + (ez_i >>> STAGE);
         ez_in  = ez_i - (ex_i >>> STAGE);
         acc_in = acc_i + ATAN_TABLE[STAGE];
      end else begin
         vx_in  = vx_i - (vy_i >>> STAGE);
         vy_in  = vy_i + (vx_i >>> STAGE);
         sx_in  = sx_i - (sz_i >>> STAGE);
         sz_in  = sz_i + (sx_i >>> STAGE);
         ex_in  = ex_i - (ez_i >>> STAGE);
         ez_in  = ez_i + (ex_i >>> STAGE);
         acc_in = acc_i - ATAN_TABLE[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      vx_ff  <= vx_in;
      vy_ff  <= vy_in;
      sx_ff  <= sx_in;
      sz_ff  <= sz_in;
      ex_ff  <= ex_in;
      ez_ff  <= ez_in;
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_i;
      end
   end

   assign vx_o    = vx_ff;
   assign vy_o    = vy_ff;
   assign sx_o    = sx_ff;
   assign sz_o    = sz_ff;
   assign ex_o    = ex_ff;
   assign ez_o    = ez_ff;
   assign acc_o   = acc_ff;
   assign flags_o = flags_ff;

endmodule

`default_nettype wire

// File: sv/spar_post.sv
// Back end: CORDIC gain correction, saturation, body angle and facing class.
`default_nettype none

module spar_post import spar_pkg::*; #(
   parameter int DATA_WIDTH = DEFAULT_COORD_WIDTH + GUARD_BITS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic signed [DATA_WIDTH-1:0]     sx,
   input  wire logic signed [DATA_WIDTH-1:0]     sz,
   input  wire logic signed [DATA_WIDTH-1:0]     ex,
   input  wire logic signed [DATA_WIDTH-1:0]     ez,
   input  wire logic signed [ACC_WIDTH-1:0]      acc,
   input  wire spar_flags_type                   flags,
   input  wire logic [THRESHOLD_WIDTH-1:0]       threshold,
   output logic                                  valid,
   output logic signed [OUT_WIDTH-1:0]           rot_start_x,
   output logic signed [OUT_WIDTH-1:0]           rot_start_z,
   output logic signed [OUT_WIDTH-1:0]           rot_end_x,
   output logic signed [OUT_WIDTH-1:0]           rot_end_z,
   output logic signed [OUT_WIDTH-1:0]           body_angle,
   output logic [1:0]                            facing,
   output logic                                  degenerate
);

   localparam int PROD_WIDTH = DATA_WIDTH + KINV_WIDTH;
   localparam logic signed [PROD_WIDTH-1:0] GAIN_ROUND = PROD_WIDTH'(1) <<< (GAIN_SHIFT - 1);
   localparam logic signed [PROD_WIDTH-1:0] SAT_MIN    = PROD_WIDTH'(OUT_MIN);
   localparam logic signed [PROD_WIDTH-1:0] SAT_MAX    = PROD_WIDTH'(OUT_MAX);

   logic signed [DATA_WIDTH-1:0]  pts [4];
   logic signed [PROD_WIDTH-1:0]  prod_in [4];
   logic signed [PROD_WIDTH-1:0]  prod_ff [4];
   logic signed [ACC_WIDTH-1:0]   acc_ff;
   spar_flags_type                flags_ff;

   logic signed [PROD_WIDTH-1:0]  scaled [4];
   logic signed [OUT_WIDTH-1:0]   rot_in [4];
   logic signed [OUT_WIDTH-1:0]   rot_ff [4];
   logic signed [ACC_WIDTH-1:0]   phi, psi, thr;
   logic signed [OUT_WIDTH-1:0]   angle_in, angle_ff;
   logic [1:0]                    facing_in, facing_ff;
   logic                          valid_ff, degenerate_ff;

   assign pts[0] = sx;
   assign pts[1] = sz;
   assign pts[2] = ex;
   assign pts[3] = ez;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = PROD_WIDTH'(pts[k]) * PROD_WIDTH'(KINV_Q20);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= prod_in[k];
      end
      acc_ff <= acc;
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         scaled[k] = (prod_ff[k] + GAIN_ROUND) >>> GAIN_SHIFT;
         if (flags_ff.degenerate) begin
            rot_in[k] = '0;
         end else if (scaled[k] < SAT_MIN) begin
            rot_in[k] = OUT_MIN;
         end else if (scaled[k] > SAT_MAX) begin
            rot_in[k] = OUT_MAX;
         end else begin
            rot_in[k] = scaled[k][OUT_WIDTH-1:0];
         end
      end

      phi = (acc_ff + ANGLE_ROUND) >>> 8;
      psi = -phi;
      if (psi > HALF_TURN_OUT) begin
         psi = psi - FULL_TURN_OUT;
      end
      if (psi <= -HALF_TURN_OUT) begin
         psi = psi + FULL_TURN_OUT;
      end
      // A level shoulder line gives an exact angle rather than the CORDIC residue.
      if (flags_ff.dz_zero) begin
         psi = flags_ff.dx_neg ? HALF_TURN_OUT : '0;
      end

      thr = ACC_WIDTH'({threshold, 8'h00});
      priority if (flags_ff.degenerate) begin
         facing_in = FACING_FORWARD;
      end else if (psi >= thr) begin
         facing_in = FACING_LEFT;
      end else if (psi <= -thr) begin
         facing_in = FACING_RIGHT;
      end else begin
         facing_in = FACING_FORWARD;
      end

      angle_in = flags_ff.degenerate ? '0 : psi[OUT_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         rot_ff[k] <= rot_in[k];
      end
      angle_ff      <= angle_in;
      facing_ff     <= facing_in;
      degenerate_ff <= flags_ff.degenerate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         flags_ff <= flags;
         valid_ff <= flags_ff.valid;
      end
   end

   assign valid       = valid_ff;
   assign rot_start_x = rot_ff[0];
   assign rot_start_z = rot_ff[1];
   assign rot_end_x   = rot_ff[2];
   assign rot_end_z   = rot_ff[3];
   assign body_angle  = angle_ff;
   assign facing      = facing_ff;
   assign degenerate  = degenerate_ff;

endmodule

`default_nettype wire

// File: sv/shoulder_aligned_point_rotation_core.sv
// Top level of the shoulder-aligned point rotation core.
//
// A request is taken on every cycle in which start is high; busy never rises, so a new
// request may follow in the very next cycle. A result passes through one input stage,
// the row of micro-rotation cells and two output stages (gain multiply, then rounding
// and saturation). Each result is shown on the rsp_ ports for exactly one cycle with
// rsp_valid high and must be captured then: the receiver cannot hold it off. The facing
// threshold may be changed over the register port only while no request is in flight.
`default_nettype none

module shoulder_aligned_point_rotation_core import spar_pkg::*; #(
   parameter int COORD_WIDTH   = DEFAULT_COORD_WIDTH,
   parameter int CORDIC_STAGES = DEFAULT_CORDIC_STAGES
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_WIDTH-1:0] req_left_shoulder_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_left_shoulder_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_right_shoulder_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_right_shoulder_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_start_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_end_z,
   output logic                               rsp_valid,
   output logic signed [OUT_WIDTH-1:0]        rsp_rot_start_x,
   output logic signed [OUT_WIDTH-1:0]        rsp_rot_start_z,
   output logic signed [OUT_WIDTH-1:0]        rsp_rot_end_x,
   output logic signed [OUT_WIDTH-1:0]        rsp_rot_end_z,
   output logic signed [OUT_WIDTH-1:0]        rsp_body_angle,
   output logic [1:0]                         rsp_facing,
   output logic                               rsp_degenerate,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [ADDR_WIDTH-1:0]         paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [CSR_DATA_WIDTH-1:0]          prdata,
   output logic                               pready
);

   localparam int DATA_WIDTH = COORD_WIDTH + GUARD_BITS;

   logic [THRESHOLD_WIDTH-1:0]    threshold_ff, threshold_in;
   logic                          csr_write;

   logic signed [DATA_WIDTH-1:0]  vx_chain  [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]  vy_chain  [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]  sx_chain  [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]  sz_chain  [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]  ex_chain  [CORDIC_STAGES+1];
   logic signed [DATA_WIDTH-1:0]  ez_chain  [CORDIC_STAGES+1];
   logic signed [ACC_WIDTH-1:0]   acc_chain [CORDIC_STAGES+1];
   spar_flags_type                flags_chain [CORDIC_STAGES+1];

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr == REG_THRESHOLD_ADDR);
   assign threshold_in = csr_write ? pwdata[THRESHOLD_WIDTH-1:0] : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   assign prdata = (paddr == REG_THRESHOLD_ADDR) ?
                   CSR_DATA_WIDTH'(threshold_ff) : '0;

   assign busy = 1'b0;

   spar_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_prep (
      .clock            (clock),
      .reset            (reset),
      .accept           (start && !busy),
      .left_shoulder_x  (req_left_shoulder_x),
      .left_shoulder_z  (req_left_shoulder_z),
      .right_shoulder_x (req_right_shoulder_x),
      .right_shoulder_z (req_right_shoulder_z),
      .start_x          (req_start_x),
      .start_z          (req_start_z),
      .end_x            (req_end_x),
      .end_z            (req_end_z),
      .vx               (vx_chain[0]),
      .vy               (vy_chain[0]),
      .sx               (sx_chain[0]),
      .sz               (sz_chain[0]),
      .ex               (ex_chain[0]),
      .ez               (ez_chain[0]),
      .acc              (acc_chain[0]),
      .flags            (flags_chain[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      spar_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .STAGE      (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .vx_i    (vx_chain[i]),
         .vy_i    (vy_chain[i]),
         .sx_i    (sx_chain[i]),
         .sz_i    (sz_chain[i]),
         .ex_i    (ex_chain[i]),
         .ez_i    (ez_chain[i]),
         .acc_i   (acc_chain[i]),
         .flags_i (flags_chain[i]),
         .vx_o    (vx_chain[i+1]),
         .vy_o    (vy_chain[i+1]),
         .sx_o    (sx_chain[i+1]),
         .sz_o    (sz_chain[i+1]),
         .ex_o    (ex_chain[i+1]),
         .ez_o    (ez_chain[i+1]),
         .acc_o   (acc_chain[i+1]),
         .flags_o (flags_chain[i+1])
      );
   end

   spar_post #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_post (
      .clock       (clock),
      .reset       (reset),
      .sx          (sx_chain[CORDIC_STAGES]),
      .sz          (sz_chain[CORDIC_STAGES]),
      .ex          (ex_chain[CORDIC_STAGES]),
      .ez          (ez_chain[CORDIC_STAGES]),
      .acc         (acc_chain[CORDIC_STAGES]),
      .flags       (flags_chain[CORDIC_STAGES]),
      .threshold   (threshold_ff),
      .valid       (rsp_valid),
      .rot_start_x (rsp_rot_start_x),
      .rot_start_z (rsp_rot_start_z),
      .rot_end_x   (rsp_rot_end_x),
      .rot_end_z   (rsp_rot_end_z),
      .body_angle  (rsp_body_angle),
      .facing      (rsp_facing),
      .degenerate  (rsp_degenerate)
   );

endmodule

`default_nettype wire

// File: sv/spar_checker.sv
// Port-level checks for the shoulder-aligned point rotation core, bound to its top level.
`default_nettype none

module spar_checker import spar_pkg::*; #(
   parameter int CORDIC_STAGES = DEFAULT_CORDIC_STAGES
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic                        rsp_valid,
   input wire logic signed [OUT_WIDTH-1:0] rsp_rot_start_x,
   input wire logic signed [OUT_WIDTH-1:0] rsp_rot_start_z,
   input wire logic signed [OUT_WIDTH-1:0] rsp_rot_end_x,
   input wire logic signed [OUT_WIDTH-1:0] rsp_rot_end_z,
   input wire logic signed [OUT_WIDTH-1:0] rsp_body_angle,
   input wire logic [1:0]                  rsp_facing,
   input wire logic                        rsp_degenerate
);

   localparam int LATENCY   = CORDIC_STAGES + 3;
   localparam int AGE_WIDTH = $clog2(LATENCY + 1);

   logic [AGE_WIDTH-1:0] age_ff, age_in;

   // Counts cycles since reset so the latency check only looks at requests it saw.
   assign age_in = (age_ff == AGE_WIDTH'(LATENCY)) ? age_ff : age_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff <= '0;
      end else begin
         age_ff <= age_in;
      end
   end

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      (age_ff == AGE_WIDTH'(LATENCY)) |-> (rsp_valid == $past(start && !busy, LATENCY)))
      else $error("result strobe does not follow a request by the pipeline latency");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |->
         (rsp_rot_start_x == '0 && rsp_rot_start_z == '0 && rsp_rot_end_x == '0 &&
          rsp_rot_end_z == '0 && rsp_body_angle == '0 && rsp_facing == FACING_FORWARD))
      else $error("coinciding shoulders gave a non-zero result");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_body_angle > -17'sd46080 && rsp_body_angle <= 17'sd46080))
      else $error("body angle outside the half-open turn");

   a_facing_sign: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_facing == FACING_RIGHT) |-> rsp_body_angle[OUT_WIDTH-1])
      else $error("facing right reported with a non-negative body angle");

   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !busy)
      else $error("core refused a request");

endmodule

bind shoulder_aligned_point_rotation_core spar_checker #(
   .CORDIC_STAGES (CORDIC_STAGES)
) u_spar_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_rot_start_x (rsp_rot_start_x),
   .rsp_rot_start_z (rsp_rot_start_z),
   .rsp_rot_end_x   (rsp_rot_end_x),
   .rsp_rot_end_z   (rsp_rot_end_z),
   .rsp_body_angle  (rsp_body_angle),
   .rsp_facing      (rsp_facing),
   .rsp_degenerate  (rsp_degenerate)
);

`default_nettype wire
